FILE: rtl/core/euler_xyz_to_rotation_matrix_defines.svh
// assertion macros for the euler rotation block
`ifndef EULER_XYZ_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_XYZ_TO_ROTATION_MATRIX_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/core/exrm_pkg.sv
package exrm_pkg;
    // internal fixed point: q4.30 in 34 bits
    localparam int INT_FRAC     = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int PHASE_WIDTH  = 32;
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sh26DD3B6A;

    typedef logic signed [33:0] cval_t;
    typedef logic signed [31:0] phase_t;

    // arctangent table in units of one turn over 2^32
    function automatic phase_t atan_turns(input int idx);
        phase_t v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            24:      v = 32'h00000029;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000003;
            29:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction
endpackage

FILE: rtl/core/euler_xyz_to_rotation_matrix.sv
// euler xyz angles to 3x3 rotation matrix, fully pipelined
// pipeline stages: 1 reduce, 30 cordic,
// 2 product, 1 sum, 1 round, 1 output register
// throughput: one transaction per cycle; a stall freezes the whole pipeline in place
// reset: rst_n asynchronous active low clears all valid bits, payload is not reset
`include "euler_xyz_to_rotation_matrix_defines.svh"
module euler_xyz_to_rotation_matrix #(
    parameter int ANGLE_WIDTH   = 16,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // angle_x [15:0], angle_y [31:16], angle_z [47:32]
    input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // row0_col0 lowest, then row0_col1 .. row2_col2, each OUT_FRAC_BITS+2 bits
    output logic [((9*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);
    localparam int OW     = OUT_FRAC_BITS + 2;
    localparam int TDW    = ((9*OW+7)/8)*8;
    localparam int NCS    = exrm_pkg::CORDIC_STEPS;
    localparam int SH     = exrm_pkg::INT_FRAC - OUT_FRAC_BITS;
    localparam int DEPTH  = NCS + 6;

    typedef logic signed [33:0] cv_t;
    typedef logic signed [31:0] ph_t;

    // global advance: whole pipe moves unless output is held
    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic [DEPTH-1:0] vld_reg;

    // stage 0: quadrant reduction to signed phase
    logic [2:0] flip0_reg;
    ph_t        z0_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                logic [ANGLE_WIDTH-1:0] raw;
                logic [31:0] p;
                raw = s_axis_tdata[a*ANGLE_WIDTH +: ANGLE_WIDTH];
                p = {raw, {(32-ANGLE_WIDTH){1'b0}}} ;
                flip0_reg[a] <= (p[31] ^ p[30]);
                z0_reg[a] <= (p[31] ^ p[30]) ? (p + 32'h80000000) : p;
            end
        end
    end

    // cordic stages: step i reads x_st/y_st/z_st[i] and writes x_reg/y_reg/z_reg[i]
    cv_t        x_reg [3][NCS];
    cv_t        y_reg [3][NCS];
    ph_t        z_reg [3][NCS-1];
    logic [2:0] fl_reg [NCS];
    cv_t        x_st [3][NCS];
    cv_t        y_st [3][NCS];
    ph_t        z_st [3][NCS];
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            x_st[a][0] = exrm_pkg::CORDIC_GAIN_INV;
            y_st[a][0] = '0;
            z_st[a][0] = z0_reg[a];
            for (int i = 1; i < NCS; i++)
            begin
                x_st[a][i] = x_reg[a][i-1];
                y_st[a][i] = y_reg[a][i-1];
                z_st[a][i] = z_reg[a][i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fl_reg[0] <= flip0_reg;
            for (int i = 1; i < NCS; i++)
            begin
                fl_reg[i] <= fl_reg[i-1];
            end
            for (int i = 0; i < NCS; i++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (!z_st[a][i][31])
                    begin
                        x_reg[a][i] <= x_st[a][i] - (y_st[a][i] >>> i);
                        y_reg[a][i] <= y_st[a][i] + (x_st[a][i] >>> i);
                    end
                    else
                    begin
                        x_reg[a][i] <= x_st[a][i] + (y_st[a][i] >>> i);
                        y_reg[a][i] <= y_st[a][i] - (x_st[a][i] >>> i);
                    end
                end
            end
            // residual angle is not needed after the last step
            for (int i = 0; i < NCS-1; i++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (!z_st[a][i][31])
                    begin
                        z_reg[a][i] <= z_st[a][i] - exrm_pkg::atan_turns(i);
                    end
                    else
                    begin
                        z_reg[a][i] <= z_st[a][i] + exrm_pkg::atan_turns(i);
                    end
                end
            end
        end
    end

    // sign fix: sine and cosine per axis
    cv_t s_c [3];
    cv_t c_c [3];
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            c_c[a] = fl_reg[NCS-1][a] ? -x_reg[a][NCS-1] : x_reg[a][NCS-1];
            s_c[a] = fl_reg[NCS-1][a] ? -y_reg[a][NCS-1] : y_reg[a][NCS-1];
        end
    end

    function automatic cv_t qmul(input cv_t a, input cv_t b);
        logic signed [67:0] pr;
        pr = a * b + (68'sd1 <<< 29);
        return cv_t'(pr >>> 30);
    endfunction

    // product stage 1: first-level products
    cv_t sx1_reg, cx1_reg, sy1_reg;
    cv_t sycz_reg, sysz_reg, cycz_reg, cysz_reg, cxcy_reg, sxcy_reg, cxsz_reg, cxcz_reg;
    cv_t sxsz_reg, sxcz_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx1_reg  <= s_c[0];
            cx1_reg  <= c_c[0];
            sy1_reg  <= s_c[1];
            sycz_reg <= qmul(s_c[1], c_c[2]);
            sysz_reg <= qmul(s_c[1], s_c[2]);
            cycz_reg <= qmul(c_c[1], c_c[2]);
            cysz_reg <= qmul(c_c[1], s_c[2]);
            cxcy_reg <= qmul(c_c[0], c_c[1]);
            sxcy_reg <= qmul(s_c[0], c_c[1]);
            cxsz_reg <= qmul(c_c[0], s_c[2]);
            cxcz_reg <= qmul(c_c[0], c_c[2]);
            sxsz_reg <= qmul(s_c[0], s_c[2]);
            sxcz_reg <= qmul(s_c[0], c_c[2]);
        end
    end

    // product stage 2: second-level products, pass the rest
    cv_t e_reg [9];
    cv_t p1_reg, p2_reg, p3_reg, p4_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg[0] <= cycz_reg;
            e_reg[1] <= -cysz_reg;
            e_reg[2] <= sy1_reg;
            e_reg[3] <= cxsz_reg;
            e_reg[4] <= cxcz_reg;
            e_reg[5] <= -sxcy_reg;
            e_reg[6] <= sxsz_reg;
            e_reg[7] <= sxcz_reg;
            e_reg[8] <= cxcy_reg;
            p1_reg   <= qmul(sx1_reg, sycz_reg);
            p2_reg   <= qmul(sx1_reg, sysz_reg);
            p3_reg   <= qmul(cx1_reg, sycz_reg);
            p4_reg   <= qmul(cx1_reg, sysz_reg);
        end
    end

    // sum stage
    cv_t f_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg[0] <= e_reg[0];
            f_reg[1] <= e_reg[1];
            f_reg[2] <= e_reg[2];
            f_reg[3] <= e_reg[3] + p1_reg;
            f_reg[4] <= e_reg[4] - p2_reg;
            f_reg[5] <= e_reg[5];
            f_reg[6] <= e_reg[6] - p3_reg;
            f_reg[7] <= e_reg[7] + p4_reg;
            f_reg[8] <= e_reg[8];
        end
    end

    // round stage
    cv_t g_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
            begin
                if (SH == 0)
                begin
                    g_reg[k] <= f_reg[k];
                end
                else
                begin
                    g_reg[k] <= (f_reg[k] + (cv_t'(1) <<< (SH-1))) >>> SH;
                end
            end
        end
    end

    // saturate into output register
    localparam cv_t HI = (cv_t'(1) <<< (OW-1)) - cv_t'(1);
    localparam cv_t LO = -(cv_t'(1) <<< (OW-1));
    logic [TDW-1:0] tdata_next;
    always_comb
    begin
        tdata_next = '0;
        for (int k = 0; k < 9; k++)
        begin
            cv_t r;
            r = g_reg[k];
            if (r > HI)
            begin
                r = HI;
            end
            if (r < LO)
            begin
                r = LO;
            end
            tdata_next[k*OW +: OW] = r[OW-1:0];
        end
    end

    logic [TDW-1:0] tdata_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tdata_reg <= tdata_next;
        end
    end
    assign m_axis_tdata = tdata_reg;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    `ASSERT_IMPLIES(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready)
    `ASSERT_NEXT(a_hold_on_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(vld_reg))
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
endmodule

FILE: tb/tb_euler_xyz_to_rotation_matrix.sv
module tb_euler_xyz_to_rotation_matrix;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW     = 16;
    localparam int OFB    = 16;
    localparam int OW     = OFB + 2;
    localparam int DW     = ((9 * OW + 7) / 8) * 8;
    localparam int N_RAND = 1950;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [3*AW-1:0] s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [DW-1:0] m_axis_tdata;

    typedef logic [9*OW-1:0] matrix_t;

    logic [3*AW-1:0] pending_angles[$];
    matrix_t         expected_matrices[$];
    int              errors;
    bit              stim_done;
    int              idle_phase;
    int              hold_count;

    euler_xyz_to_rotation_matrix #(
        .ANGLE_WIDTH(AW),
        .OUT_FRAC_BITS(OFB)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // floor shift on a signed value
    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshift(longint v, int s);
        if (s == 0)
            return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint fxmul(longint a, longint b);
        return rshift(a * b, exrm_pkg::INT_FRAC);
    endfunction

    function automatic longint atan_step(int i);
        longint t[30] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
            64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
            64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
        return t[i];
    endfunction

    // cordic sine and cosine in q2.30
    function automatic void angle_sin_cos(input logic [AW-1:0] ang, output longint sn,
                                          output longint cs);
        logic [31:0] p;
        bit          flip;
        longint      x, y, z, dx, dy;
        p = {ang, {(32 - AW){1'b0}}};
        flip = (p[31:30] == 2'd1) || (p[31:30] == 2'd2);
        if (flip)
            p = p + 32'h80000000;
        z = longint'($signed(p));
        x = 64'h26DD3B6A;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_step(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_step(i);
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic logic [OW-1:0] to_element(longint v);
        longint r;
        longint hi;
        longint lo;
        r = rshift(v, exrm_pkg::INT_FRAC - OFB);
        hi = (longint'(1) << (OW - 1)) - 1;
        lo = -(longint'(1) << (OW - 1));
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return r[OW-1:0];
    endfunction

    function automatic matrix_t rotation_of(logic [3*AW-1:0] a);
        longint  sx, cx, sy, cy, sz, cz, sycz, sysz;
        longint  e[9];
        matrix_t m;
        angle_sin_cos(a[AW-1:0], sx, cx);
        angle_sin_cos(a[2*AW-1:AW], sy, cy);
        angle_sin_cos(a[3*AW-1:2*AW], sz, cz);
        sycz = fxmul(sy, cz);
        sysz = fxmul(sy, sz);
        e[0] = fxmul(cy, cz);
        e[1] = -fxmul(cy, sz);
        e[2] = sy;
        e[3] = fxmul(cx, sz) + fxmul(sx, sycz);
        e[4] = fxmul(cx, cz) - fxmul(sx, sysz);
        e[5] = -fxmul(sx, cy);
        e[6] = fxmul(sx, sz) - fxmul(cx, sycz);
        e[7] = fxmul(sx, cz) + fxmul(cx, sysz);
        e[8] = fxmul(cx, cy);
        for (int i = 0; i < 9; i++)
            m[i*OW +: OW] = to_element(e[i]);
        return m;
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // stimulus
    initial
    begin
        logic [AW-1:0] specials[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                       16'h7FFF, 16'h8001, 16'h0001, 16'hFFFF};
        logic [63:0]   rnd;
        errors = 0;
        stim_done = 0;
        idle_phase = 0;
        hold_count = 0;
        for (int i = 0; i < 8; i++)
            pending_angles = {pending_angles, {specials[(i + 5) % 8], specials[(i + 2) % 8],
                                               specials[i]}};
        pending_angles = {pending_angles, 48'h0};
        pending_angles = {pending_angles, 48'hFFFF_FFFF_FFFF};
        pending_angles = {pending_angles, 48'h5555_AAAA_5555};
        pending_angles = {pending_angles, 48'hAAAA_5555_AAAA};
        for (int i = 0; i < N_RAND; i++)
        begin
            rnd = {$urandom, $urandom};
            pending_angles = {pending_angles, rnd[3*AW-1:0]};
        end
    end

    // reset and phase control
    initial
    begin
        int total;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        total = pending_angles.size();
        while (pending_angles.size() >= 2 * total / 3)
            @(posedge clk);
        idle_phase = 1;
        while (pending_angles.size() >= total / 3)
            @(posedge clk);
        idle_phase = 2;
        while (pending_angles.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        stim_done = 1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                expected_matrices = {expected_matrices, rotation_of(s_axis_tdata)};
            if (pending_angles.size() > 0 &&
                !(idle_phase == 0 && roll(37)) && !(idle_phase == 1 && roll(79)))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_angles.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver backpressure with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_count < 300 && pending_angles.size() < 1000 && idle_phase == 1)
        begin
            hold_count    <= hold_count + 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_phase == 0)
            m_axis_tready <= !roll(79);
        else if (idle_phase == 1)
            m_axis_tready <= !roll(37);
        else
            m_axis_tready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        matrix_t exp_m;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_matrices.size() == 0)
            begin
                $error("result with no expectation waiting");
                errors++;
            end
            else
            begin
                exp_m = expected_matrices.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_axis_tdata[i*OW +: OW] !== exp_m[i*OW +: OW])
                    begin
                        $error("row%0d_col%0d expected %h actual %h", i / 3, i % 3,
                               exp_m[i*OW +: OW], m_axis_tdata[i*OW +: OW]);
                        errors++;
                    end
            end
        end
    end

    // end of run
    initial
    begin
        while (!stim_done)
            @(posedge clk);
        while (expected_matrices.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0 && expected_matrices.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // timeout
    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end
endmodule
